// ===== hdl/smfd_pkg.sv =====
package smfd_pkg;

   // Configuration port word types.
   typedef logic [3:0]  csr_index_type;
   typedef logic [23:0] csr_data_type;

   // Payload types of the sample channels.
   typedef logic signed [15:0] sample_type;
   typedef logic signed [18:0] offset_type;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_BASE_DELAY     = 4'd0;
   localparam csr_index_type CSR_SPREAD_DELAY   = 4'd1;
   localparam csr_index_type CSR_FEEDBACK_GAIN  = 4'd2;
   localparam csr_index_type CSR_LOWPASS_COEFF  = 4'd3;
   localparam csr_index_type CSR_HIGHPASS_COEFF = 4'd4;
   localparam csr_index_type CSR_WET_MIX        = 4'd5;
   localparam csr_index_type CSR_DUCK_DEPTH     = 4'd6;
   localparam csr_index_type CSR_PING_PONG      = 4'd7;

   // Envelope follower coefficients (Q0.24) for 5 ms attack and 150 ms release at 48 kHz.
   localparam int ATTACK_COEF    = 69760;
   localparam int RELEASE_COEF   = 2330;
   // Ducking gain limits (Q1.16) and the depth above which ducking turns on.
   localparam int GAIN_FLOOR     = 3277;
   localparam int GAIN_UNITY     = 65536;
   localparam int DUCK_THRESHOLD = 327;

   // Arithmetic shift right with rounding half toward plus infinity.
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] x,
                                                      input int n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      return (x + half) >>> n;
   endfunction

   // Saturation to the 24 bit signed filter state range.
   function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
      logic signed [23:0] r;
      if (x > 64'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (x < -64'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

   // Saturation to the 16 bit signed output range.
   function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
      logic signed [15:0] r;
      if (x > 64'sd32767) begin
         r = 16'sh7FFF;
      end else if (x < -64'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = x[15:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/stereo_modulated_feedback_delay.sv =====
// Stereo modulated feedback delay with four-point Hermite interpolation.
//
// Input channel (req_*): one stereo dry sample pair and a signed modulation
// offset per word. Result channel (rsp_*): one mixed stereo pair per input word.
// Configuration (csr_*): register writes by index; the user must write only while
// the block is idle, which the block itself does not enforce; csr_ready is always high and unknown indexes are ignored.
//
// The block takes no new word from acceptance until the result word is handed
// on; the envelope and ducking gain steps run only when ducking is on. The work
// is serialized by the one shared multiplier, which does all products of the
// envelope, interpolation, feedback filters and mix one after another, and by
// the single read port of each delay memory, which fetches the four taps of a
// channel one after another.
//
// Reset restores the register defaults, clears filter and envelope state and
// sets the write index to zero. The delay memories are not cleared: a fill
// flag and the write index mark which entries hold data, and older entries
// read as zero until the write index first wraps.
// A result word waits in its own register while the receiver stalls; the next
// input word is accepted meanwhile, and its result waits for the slot to free.
module stereo_modulated_feedback_delay #(
   parameter int DELAY_DEPTH = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  smfd_pkg::sample_type     req_left_in,
   input  smfd_pkg::sample_type     req_right_in,
   input  smfd_pkg::offset_type     req_mod_offset,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output smfd_pkg::sample_type     rsp_left_out,
   output smfd_pkg::sample_type     rsp_right_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  smfd_pkg::csr_index_type  csr_index,
   input  smfd_pkg::csr_data_type   csr_data
);

   import smfd_pkg::*;

   localparam int AW  = $clog2(DELAY_DEPTH);
   localparam int SB  = SAMPLE_BITS;
   localparam int CW  = SB + 4;
   localparam int MW  = SB + 32;
   localparam int DLW = (AW + 10 > 28) ? AW + 10 : 28;
   localparam logic signed [DLW-1:0] DEL_LO = DLW'(512);
   localparam logic signed [DLW-1:0] DEL_HI = DLW'((DELAY_DEPTH - 2) * 256);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
   localparam logic signed [AW+1:0] DEPTH_S = (AW + 2)'(DELAY_DEPTH);
   localparam logic signed [63:0] SMP_MAX = 64'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [63:0] SMP_MIN = -SMP_MAX - 64'sd1;

   typedef enum logic [4:0] {
      S_IDLE, S_DELAY, S_ENV_M, S_ENV_A, S_DUCK_M, S_DUCK_A, S_WG_M, S_WG_A,
      S_ADDR, S_READ, S_COEF, S_HERM_M, S_HERM_A,
      S_FB_GM, S_FB_GA, S_FB_LM, S_FB_LA, S_FB_HM, S_FB_HA,
      S_MIX_M, S_MIX_A, S_MIX_R, S_DONE
   } state_type;

   // Configuration registers.
   logic [23:0] base_delay_ff, spread_delay_ff;
   logic [15:0] feedback_gain_ff, lowpass_coeff_ff, highpass_coeff_ff;
   logic [15:0] wet_mix_ff, duck_depth_ff;
   logic        ping_pong_ff;

   // Sequencer and datapath registers.
   state_type                state_ff;
   logic                     ch_ff;
   logic [2:0]               rcnt_ff;
   logic [1:0]               hstep_ff;
   logic signed [15:0]       dry_ff [2];
   logic signed [18:0]       mod_ff;
   logic [AW-1:0]            d1_ff [2];
   logic [7:0]               t_ff [2];
   logic [23:0]              env_ff;
   logic [16:0]              gain_ff;
   logic [16:0]              wg_ff;
   logic [AW-1:0]            addr_ff;
   logic                     rvalid_ff;
   logic signed [SB-1:0]     rd_l_ff, rd_r_ff;
   logic signed [SB-1:0]     tap_ff [4];
   logic signed [CW-1:0]     c1_ff, c2_ff, c3_ff;
   logic signed [CW-1:0]     wet_ff [2];
   logic signed [63:0]       acc_ff, prod_ff;
   logic signed [23:0]       lp_ff [2], hs_ff [2];
   logic [AW-1:0]            wi_ff;
   logic                     full_ff;
   logic signed [15:0]       out_ff [2];
   logic                     rsp_valid_ff;
   logic signed [15:0]       rsp_left_ff, rsp_right_ff;

   // Delay memories.
   logic signed [SB-1:0]     mem_l [DELAY_DEPTH];
   logic signed [SB-1:0]     mem_r [DELAY_DEPTH];

   // Combinational next values.
   logic signed [DLW-1:0]    del_l_in, del_r_in;
   logic [24:0]              level_in;
   logic signed [63:0]       level_s, env_s, diff_s, env_in;
   logic signed [63:0]       gain_s;
   logic [16:0]              gain_in;
   logic signed [AW+1:0]     start_s;
   logic [AW-1:0]            start_in;
   logic signed [SB-1:0]     rsel_in;
   logic signed [63:0]       y_m1, y_0, y_1, y_2;
   logic signed [63:0]       x_s, lp_in, hs_in, fb_s, wsum_s;
   logic signed [SB-1:0]     wdata_in;
   logic signed [CW-1:0]     src_in;
   logic signed [MW-1:0]     mul_a;
   logic signed [18:0]       mul_b;
   logic signed [MW+18:0]    mul_p;
   logic                     done_go;
   logic [15:0]              abs_l, abs_r;

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;
   assign done_go       = (state_ff == S_DONE) && !(rsp_valid_ff && rsp_stall);

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff     <= 24'd256000;
         spread_delay_ff   <= 24'd0;
         feedback_gain_ff  <= 16'd16384;
         lowpass_coeff_ff  <= 16'd32768;
         highpass_coeff_ff <= 16'd512;
         wet_mix_ff        <= 16'd32768;
         duck_depth_ff     <= 16'd0;
         ping_pong_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_DELAY:     base_delay_ff     <= csr_data;
            CSR_SPREAD_DELAY:   spread_delay_ff   <= csr_data;
            CSR_FEEDBACK_GAIN:  feedback_gain_ff  <= csr_data[15:0];
            CSR_LOWPASS_COEFF:  lowpass_coeff_ff  <= csr_data[15:0];
            CSR_HIGHPASS_COEFF: highpass_coeff_ff <= csr_data[15:0];
            CSR_WET_MIX:        wet_mix_ff        <= csr_data[15:0];
            CSR_DUCK_DEPTH:     duck_depth_ff     <= csr_data[15:0];
            CSR_PING_PONG:      ping_pong_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamped fractional delays of both channels.
   always_comb begin
      del_l_in = DLW'($signed({1'b0, base_delay_ff})) + DLW'(mod_ff);
      del_r_in = del_l_in + DLW'($signed({1'b0, spread_delay_ff}));
      if (del_l_in < DEL_LO) del_l_in = DEL_LO;
      if (del_l_in > DEL_HI) del_l_in = DEL_HI;
      if (del_r_in < DEL_LO) del_r_in = DEL_LO;
      if (del_r_in > DEL_HI) del_r_in = DEL_HI;
   end

   // Peak envelope and ducking gain.
   always_comb begin
      abs_l    = dry_ff[0][15] ? 16'(-dry_ff[0]) : 16'(dry_ff[0]);
      abs_r    = dry_ff[1][15] ? 16'(-dry_ff[1]) : 16'(dry_ff[1]);
      level_in = {1'b0, ((abs_l > abs_r) ? abs_l : abs_r), 8'd0};
      level_s  = $signed({39'd0, level_in});
      env_s    = $signed({40'd0, env_ff});
      diff_s   = level_s - env_s;
      env_in   = env_s + round_shift(prod_ff, 24);
      if (env_in < 64'sd0) env_in = 64'sd0;
      if (env_in > 64'sd16777215) env_in = 64'sd16777215;
      gain_s   = 64'(GAIN_UNITY) - round_shift(prod_ff + (prod_ff <<< 1), 23);
      if (gain_s < 64'(GAIN_FLOOR)) gain_s = 64'(GAIN_FLOOR);
      if (gain_s > 64'(GAIN_UNITY)) gain_s = 64'(GAIN_UNITY);
      gain_in  = gain_s[16:0];
   end

   // First tap address and the selected read word.
   always_comb begin
      start_s = $signed({2'b00, wi_ff}) + (AW + 2)'(1) - $signed({2'b00, d1_ff[ch_ff]});
      if (start_s < 0) start_s = start_s + DEPTH_S;
      start_in = start_s[AW-1:0];
      rsel_in  = rvalid_ff ? (ch_ff ? rd_r_ff : rd_l_ff) : '0;
      y_m1 = 64'(tap_ff[0]);
      y_0  = 64'(tap_ff[1]);
      y_1  = 64'(tap_ff[2]);
      y_2  = 64'(tap_ff[3]);
   end

   // Feedback filters and the word written back.
   always_comb begin
      src_in = (ping_pong_ff ^ ch_ff) ? wet_ff[1] : wet_ff[0];
      x_s    = round_shift(prod_ff, 15);
      lp_in  = 64'(sat24(64'(lp_ff[ch_ff]) + round_shift(prod_ff, 16)));
      hs_in  = 64'(sat24(64'(hs_ff[ch_ff]) + round_shift(prod_ff, 16)));
      fb_s   = round_shift(64'(lp_ff[ch_ff]) - hs_in, 8);
      wsum_s = 64'(dry_ff[ch_ff]) + fb_s;
      if (wsum_s > SMP_MAX) wsum_s = SMP_MAX;
      if (wsum_s < SMP_MIN) wsum_s = SMP_MIN;
      wdata_in = wsum_s[SB-1:0];
   end

   // Operand selection of the shared multiplier; the wide operand only needs
   // room for the Horner partial sums of the interpolation.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ENV_M: begin
            mul_a = MW'(diff_s);
            mul_b = (level_s > env_s) ? 19'(ATTACK_COEF) : 19'(RELEASE_COEF);
         end
         S_DUCK_M: begin
            mul_a = MW'(env_s);
            mul_b = $signed({3'b000, duck_depth_ff});
         end
         S_WG_M: begin
            mul_a = MW'($signed({1'b0, wet_mix_ff}));
            mul_b = $signed({2'b00, gain_ff});
         end
         S_HERM_M: begin
            mul_a = (hstep_ff == 2'd0) ? MW'(c3_ff) : MW'(acc_ff);
            mul_b = $signed({11'd0, t_ff[ch_ff]});
         end
         S_FB_GM: begin
            mul_a = MW'(src_in);
            mul_b = $signed({3'b000, feedback_gain_ff});
         end
         S_FB_LM: begin
            mul_a = MW'(acc_ff);
            mul_b = $signed({3'b000, lowpass_coeff_ff});
         end
         S_FB_HM: begin
            mul_a = MW'(acc_ff);
            mul_b = $signed({3'b000, highpass_coeff_ff});
         end
         S_MIX_M: begin
            mul_a = MW'(dry_ff[ch_ff]);
            mul_b = $signed(19'(17'h10000 - {1'b0, wet_mix_ff}));
         end
         S_MIX_A: begin
            mul_a = MW'(wet_ff[ch_ff]);
            mul_b = $signed({2'b00, wg_ff});
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // Delay memory ports: one read and one write per channel.
   always_ff @(posedge clock) begin
      rd_l_ff <= mem_l[addr_ff];
      if (state_ff == S_FB_HA && !ch_ff) begin
         mem_l[wi_ff] <= wdata_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_r_ff <= mem_r[addr_ff];
      if (state_ff == S_FB_HA && ch_ff) begin
         mem_r[wi_ff] <= wdata_in;
      end
   end

   // Sequencer with its datapath registers.
   always_ff @(posedge clock) begin
      prod_ff   <= 64'(mul_p);
      rvalid_ff <= full_ff || (addr_ff < wi_ff);
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         wi_ff        <= '0;
         full_ff      <= 1'b0;
         env_ff       <= '0;
         lp_ff[0]     <= '0;
         lp_ff[1]     <= '0;
         hs_ff[0]     <= '0;
         hs_ff[1]     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dry_ff[0] <= req_left_in;
                  dry_ff[1] <= req_right_in;
                  mod_ff    <= req_mod_offset;
                  state_ff  <= S_DELAY;
               end
            end
            S_DELAY: begin
               d1_ff[0] <= del_l_in[AW+7:8];
               t_ff[0]  <= del_l_in[7:0];
               d1_ff[1] <= del_r_in[AW+7:8];
               t_ff[1]  <= del_r_in[7:0];
               if (duck_depth_ff > 16'(DUCK_THRESHOLD)) begin
                  state_ff <= S_ENV_M;
               end else begin
                  gain_ff  <= 17'(GAIN_UNITY);
                  state_ff <= S_WG_M;
               end
            end
            S_ENV_M:  state_ff <= S_ENV_A;
            S_ENV_A: begin
               env_ff   <= env_in[23:0];
               state_ff <= S_DUCK_M;
            end
            S_DUCK_M: state_ff <= S_DUCK_A;
            S_DUCK_A: begin
               gain_ff  <= gain_in;
               state_ff <= S_WG_M;
            end
            S_WG_M:   state_ff <= S_WG_A;
            S_WG_A: begin
               wg_ff    <= 17'(round_shift(prod_ff, 16));
               ch_ff    <= 1'b0;
               state_ff <= S_ADDR;
            end
            S_ADDR: begin
               addr_ff  <= start_in;
               rcnt_ff  <= '0;
               state_ff <= S_READ;
            end
            // Four taps, newest first; read data arrives in the cycle after its address.
            S_READ: begin
               addr_ff <= (addr_ff == '0) ? LAST_ADDR : addr_ff - 1'b1;
               rcnt_ff <= rcnt_ff + 3'd1;
               if (rcnt_ff != 3'd0) begin
                  tap_ff[2'(rcnt_ff - 3'd1)] <= rsel_in;
               end
               if (rcnt_ff == 3'd4) begin
                  state_ff <= S_COEF;
               end
            end
            S_COEF: begin
               c1_ff    <= CW'(y_1 - y_m1);
               c2_ff    <= CW'((y_m1 <<< 1) - (y_0 <<< 2) - y_0 + (y_1 <<< 2) - y_2);
               c3_ff    <= CW'((y_2 - y_m1) + ((y_0 - y_1) <<< 1) + (y_0 - y_1));
               hstep_ff <= 2'd0;
               state_ff <= S_HERM_M;
            end
            S_HERM_M: state_ff <= S_HERM_A;
            // Horner evaluation of the cubic in t.
            S_HERM_A: begin
               case (hstep_ff)
                  2'd0: begin
                     acc_ff   <= prod_ff + (64'(c2_ff) <<< 8);
                     hstep_ff <= 2'd1;
                     state_ff <= S_HERM_M;
                  end
                  2'd1: begin
                     acc_ff   <= prod_ff + (64'(c1_ff) <<< 16);
                     hstep_ff <= 2'd2;
                     state_ff <= S_HERM_M;
                  end
                  default: begin
                     wet_ff[ch_ff] <= CW'(round_shift(prod_ff + (y_0 <<< 25), 25));
                     ch_ff         <= ~ch_ff;
                     state_ff      <= ch_ff ? S_FB_GM : S_ADDR;
                  end
               endcase
            end
            S_FB_GM:  state_ff <= S_FB_GA;
            S_FB_GA: begin
               acc_ff   <= (x_s <<< 8) - 64'(lp_ff[ch_ff]);
               state_ff <= S_FB_LM;
            end
            S_FB_LM:  state_ff <= S_FB_LA;
            S_FB_LA: begin
               lp_ff[ch_ff] <= lp_in[23:0];
               acc_ff       <= lp_in - 64'(hs_ff[ch_ff]);
               state_ff     <= S_FB_HM;
            end
            S_FB_HM:  state_ff <= S_FB_HA;
            S_FB_HA: begin
               hs_ff[ch_ff] <= hs_in[23:0];
               ch_ff        <= ~ch_ff;
               state_ff     <= ch_ff ? S_MIX_M : S_FB_GM;
            end
            S_MIX_M:  state_ff <= S_MIX_A;
            S_MIX_A: begin
               acc_ff   <= prod_ff;
               state_ff <= S_MIX_R;
            end
            S_MIX_R: begin
               out_ff[ch_ff] <= sat16(round_shift(acc_ff + prod_ff, 16));
               ch_ff         <= ~ch_ff;
               state_ff      <= ch_ff ? S_DONE : S_MIX_M;
            end
            // Hand the word to the result register and advance the write index.
            S_DONE: begin
               if (done_go) begin
                  rsp_left_ff  <= out_ff[0];
                  rsp_right_ff <= out_ff[1];
                  rsp_valid_ff <= 1'b1;
                  if (wi_ff == LAST_ADDR) begin
                     wi_ff   <= '0;
                     full_ff <= 1'b1;
                  end else begin
                     wi_ff <= wi_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The write index steps by one, wrapping, for each finished word.
   a_wi_step: assert property (@(posedge clock) disable iff (reset)
      done_go |=> (wi_ff == (($past(wi_ff) == LAST_ADDR) ? '0 : $past(wi_ff) + 1'b1)))
      else $error("write index did not advance by one");

   // Once the memories have wrapped, every entry stays valid.
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("fill flag dropped");

   // The ducking gain stays within its floor and unity.
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WG_M) |-> (gain_ff >= 17'(GAIN_FLOOR) && gain_ff <= 17'(GAIN_UNITY)))
      else $error("ducking gain out of range");

   // A result word appears only when the sequencer finishes a word.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result word without a finished computation");

endmodule
